// ===== rtl/request_timeout_table_core_assert.svh =====
// Assertion macros for the request timeout table; clocked on clk, off during reset.
`ifndef REQUEST_TIMEOUT_TABLE_CORE_ASSERT_SVH
`define REQUEST_TIMEOUT_TABLE_CORE_ASSERT_SVH

// Hold cons in the same cycle as ante.
`define RTT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Hold cons in the cycle after ante.
`define RTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rtt_pkg.sv =====
`timescale 1ns / 1ps
package rtt_pkg;

  localparam int ENTRIES   = 16;
  localparam int TAG_BITS  = 8;
  localparam int ADDR_W    = $clog2(ENTRIES);
  localparam int FUNC_W    = 2;
  localparam int IN_TAG_W  = 8;
  localparam int OUT_TAG_W = 8;
  localparam int TMO_W     = 16;
  localparam int TS_W      = 32;
  localparam int CNT_W     = 32;
  localparam int KIND_W    = 3;

  localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_STARTED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DUPLICATE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STOPPED   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd4;
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd5;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [TS_W-1:0]     start;
    logic [TMO_W-1:0]    timeout;
  } rtt_entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    rtt_entry_t        wdata;
    logic [ADDR_W-1:0] raddr;
  } rtt_mem_req_t;

  typedef struct packed {
    logic                 vld;
    logic [KIND_W-1:0]    kind;
    logic [OUT_TAG_W-1:0] tag;
    logic [TS_W-1:0]      latency;
    logic [CNT_W-1:0]     count;
    logic                 expired;
    logic                 last;
  } rtt_res_t;

  function automatic logic [TAG_BITS-1:0] tag_from_in(input logic [IN_TAG_W-1:0] t);
    logic [15:0] w;
    w = 16'(t);
    return w[TAG_BITS-1:0];
  endfunction

  function automatic logic [OUT_TAG_W-1:0] tag_to_out(input logic [TAG_BITS-1:0] t);
    logic [15:0] w;
    w = 16'(t);
    return w[OUT_TAG_W-1:0];
  endfunction

endpackage

// ===== rtl/request_timeout_table_core.sv =====
// After the accepting edge the sequencer scans every entry, drains, then drives
// the final result beat from the finish state; the outputs register it. A start
// is ignored while busy. Each item reads every entry of the entry memory (one read,
// one write port) once, one entry per cycle, then decides; a START may write one.
// A tick emits its expired beats during scan and drain, the final beat after it.
// Reset (synchronous, rst_n low) clears all valid bits, the tick and completed counters.
`timescale 1ns / 1ps
`include "request_timeout_table_core_assert.svh"
module request_timeout_table_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rtt_pkg::FUNC_W-1:0]      in_func,
  input  logic [rtt_pkg::IN_TAG_W-1:0]    in_tag,
  input  logic [rtt_pkg::TMO_W-1:0]       in_timeout_ticks,
  output logic                            out_valid,
  output logic [rtt_pkg::KIND_W-1:0]      out_kind,
  output logic [rtt_pkg::OUT_TAG_W-1:0]   out_tag_res,
  output logic [rtt_pkg::TS_W-1:0]        out_latency,
  output logic [rtt_pkg::CNT_W-1:0]       out_completed_count,
  output logic                            out_expired,
  output logic                            out_last
);
  import rtt_pkg::*;

  rtt_mem_req_t mem_req;
  rtt_entry_t   mem_rdata;
  rtt_res_t     res;

  logic                 out_valid_r;
  logic [KIND_W-1:0]    out_kind_r;
  logic [OUT_TAG_W-1:0] out_tag_r;
  logic [TS_W-1:0]      out_latency_r;
  logic [CNT_W-1:0]     out_count_r;
  logic                 out_expired_r;
  logic                 out_last_r;

  rtt_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_func          (in_func),
    .in_tag           (in_tag),
    .in_timeout_ticks (in_timeout_ticks),
    .busy             (busy),
    .mem_req          (mem_req),
    .mem_rdata        (mem_rdata),
    .res              (res)
  );

  rtt_entry_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.vld;
    end
  end

  // hold the payload between beats
  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_kind_r    <= res.kind;
      out_tag_r     <= res.tag;
      out_latency_r <= res.latency;
      out_count_r   <= res.count;
      out_expired_r <= res.expired;
      out_last_r    <= res.last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_tag_res         = out_tag_r;
  assign out_latency         = out_latency_r;
  assign out_completed_count = out_count_r;
  assign out_expired         = out_expired_r;
  assign out_last            = out_last_r;

  `RTT_ASSERT_SAME(a_run_open_busy, out_valid_r && !out_last_r, busy, "run open while idle")
  `RTT_ASSERT_NEXT(a_last_gap, out_valid_r && out_last_r, !out_valid_r, "beat after last")
  `RTT_ASSERT_SAME(a_expired_kind, out_valid_r && out_expired_r, out_kind_r == KIND_EXPIRED,
                   "expired beat with wrong kind")

endmodule

// ===== rtl/rtt_entry_mem.sv =====
`timescale 1ns / 1ps
module rtt_entry_mem (
  input  logic                 clk,
  input  rtt_pkg::rtt_mem_req_t req,
  output rtt_pkg::rtt_entry_t   rdata
);
  import rtt_pkg::*;

  rtt_entry_t mem_r [ENTRIES];
  rtt_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rdata_r <= mem_r[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rtt_seq.sv =====
`timescale 1ns / 1ps
module rtt_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rtt_pkg::FUNC_W-1:0]    in_func,
  input  logic [rtt_pkg::IN_TAG_W-1:0]  in_tag,
  input  logic [rtt_pkg::TMO_W-1:0]     in_timeout_ticks,
  output logic                          busy,
  output rtt_pkg::rtt_mem_req_t         mem_req,
  input  rtt_pkg::rtt_entry_t           mem_rdata,
  output rtt_pkg::rtt_res_t             res
);
  import rtt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } rtt_state_t;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(ENTRIES - 1);

  rtt_state_t          state_r, state_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [TMO_W-1:0]    tmo_r, tmo_nxt;
  logic [TS_W-1:0]     now_r, now_nxt;
  logic [CNT_W-1:0]    done_r, done_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [ADDR_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                found_r, found_nxt;
  logic [ADDR_W-1:0]   found_idx_r, found_idx_nxt;
  logic [TS_W-1:0]     found_start_r, found_start_nxt;
  logic                free_r, free_nxt;
  logic [ADDR_W-1:0]   free_idx_r, free_idx_nxt;
  logic                pend_r, pend_nxt;
  logic [TAG_BITS-1:0] pend_tag_r, pend_tag_nxt;

  logic            hit;
  logic [TS_W-1:0] elapsed;
  logic            over;

  assign hit     = rd_vld_r && valid_r[rd_idx_r];
  assign elapsed = now_r - mem_rdata.start;
  assign over    = elapsed > TS_W'(mem_rdata.timeout);
  assign busy    = (state_r != ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    tag_nxt         = tag_r;
    tmo_nxt         = tmo_r;
    now_nxt         = now_r;
    done_nxt        = done_r;
    valid_nxt       = valid_r;
    scan_idx_nxt    = scan_idx_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = scan_idx_r;
    found_nxt       = found_r;
    found_idx_nxt   = found_idx_r;
    found_start_nxt = found_start_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    pend_nxt        = pend_r;
    pend_tag_nxt    = pend_tag_r;
    mem_req         = '0;
    mem_req.raddr   = scan_idx_r;
    res             = '0;

    // evaluate the entry read in the previous cycle
    if (rd_vld_r) begin
      if (func_r == FUNC_TICK) begin
        if (hit && over) begin
          valid_nxt[rd_idx_r] = 1'b0;
          if (pend_r) begin
            res.vld     = 1'b1;
            res.kind    = KIND_EXPIRED;
            res.tag     = tag_to_out(pend_tag_r);
            res.expired = 1'b1;
            res.last    = 1'b0;
          end
          pend_nxt     = 1'b1;
          pend_tag_nxt = mem_rdata.tag;
        end
      end else begin
        if (hit && (mem_rdata.tag == tag_r) && !found_r) begin
          found_nxt       = 1'b1;
          found_idx_nxt   = rd_idx_r;
          found_start_nxt = mem_rdata.start;
        end
        if (!valid_r[rd_idx_r] && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = rd_idx_r;
        end
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start && (in_func != FUNC_NOP)) begin
          func_nxt     = in_func;
          tag_nxt      = tag_from_in(in_tag);
          tmo_nxt      = in_timeout_ticks;
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
          free_nxt     = 1'b0;
          pend_nxt     = 1'b0;
          if (in_func == FUNC_TICK) begin
            now_nxt = now_r + 1'b1;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = scan_idx_r;
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
        res.vld   = 1'b1;
        res.last  = 1'b1;
        case (func_r)
          FUNC_START: begin
            res.tag = tag_to_out(tag_r);
            if (found_r) begin
              res.kind = KIND_DUPLICATE;
            end else if (free_r) begin
              mem_req.we            = 1'b1;
              mem_req.waddr         = free_idx_r;
              mem_req.wdata.tag     = tag_r;
              mem_req.wdata.start   = now_r;
              mem_req.wdata.timeout = tmo_r;
              valid_nxt[free_idx_r] = 1'b1;
              res.kind              = KIND_STARTED;
            end else begin
              res.kind = KIND_FULL;
            end
          end
          FUNC_STOP: begin
            res.tag = tag_to_out(tag_r);
            if (found_r) begin
              done_nxt               = done_r + 1'b1;
              valid_nxt[found_idx_r] = 1'b0;
              res.kind               = KIND_STOPPED;
              res.latency            = now_r - found_start_r;
              res.count              = done_r + 1'b1;
            end else begin
              res.kind = KIND_NOT_FOUND;
            end
          end
          FUNC_TICK: begin
            res.kind = KIND_EXPIRED;
            if (pend_r) begin
              res.tag     = tag_to_out(pend_tag_r);
              res.expired = 1'b1;
            end
          end
          default: begin
            res.vld = 1'b0;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      now_r    <= '0;
      done_r   <= '0;
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      free_r   <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      now_r    <= now_nxt;
      done_r   <= done_nxt;
      valid_r  <= valid_nxt;
      rd_vld_r <= rd_vld_nxt;
      found_r  <= found_nxt;
      free_r   <= free_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    tag_r         <= tag_nxt;
    tmo_r         <= tmo_nxt;
    scan_idx_r    <= scan_idx_nxt;
    rd_idx_r      <= rd_idx_nxt;
    found_idx_r   <= found_idx_nxt;
    found_start_r <= found_start_nxt;
    free_idx_r    <= free_idx_nxt;
    pend_tag_r    <= pend_tag_nxt;
  end

endmodule
